// ----- sv/range_scan_obstacle_edge_finder_core_assert.svh -----
// Assertion macros for the range scan obstacle edge finder.
// Included by the top level; no other dependencies.
`ifndef RANGE_SCAN_OBSTACLE_EDGE_FINDER_CORE_ASSERT_SVH
`define RANGE_SCAN_OBSTACLE_EDGE_FINDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RSOEF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in edge finder");
`define RSOEF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in edge finder");
`else
`define RSOEF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RSOEF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/rsoef_pkg.sv -----
// Shared types and constants for the range scan obstacle edge finder.
// No dependencies.
package rsoef_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int RESULT_CAP = 32;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int PROD_W     = SLOT_W + 6;
  localparam int ANGLE_MAX  = 4095;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_SCAN  = 1'b1;
  localparam logic       REG_EDGE_THRESHOLD = 1'b0;
  localparam logic       REG_ANGLE_STEP     = 1'b1;
  localparam logic [7:0] THRESHOLD_RESET    = 8'd40;
  localparam logic [5:0] ANGLE_STEP_RESET   = 6'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic write;
    logic scan_init;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
  } status_t;

endpackage

// ----- sv/rsoef_ram.sv -----
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module rsoef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/rsoef_ctrl.sv -----
// Controller state machine for the edge finder: sequences writes and scans.
// Depends on rsoef_pkg.
module rsoef_ctrl import rsoef_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    op,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (op == OP_SCAN) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_WALK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.last_addr) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FLUSH;
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/rsoef_datapath.sv -----
// Datapath of the edge finder: reading store, edge walk pipeline and result buffer.
// Depends on rsoef_pkg and rsoef_ram.
module rsoef_datapath import rsoef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [5:0]  slot,
  input  logic [7:0]  distance,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        strobe,
  output logic        found,
  output logic [11:0] obstacle_angle,
  output logic [7:0]  obstacle_range,
  output logic        last
);

  logic [7:0]        edge_threshold;
  logic [5:0]        angle_step;
  logic [SLOTS-1:0]  filled;
  logic              in_range;
  logic [SLOT_W-1:0] waddr;
  logic [SLOT_W-1:0] addr;
  logic [7:0]        rdata_a, rdata_b;
  logic              va, vb;
  logic [7:0]        cur, mid_reading;
  logic              s1_valid, s2_valid;
  logic [SLOT_W-1:0] s1_idx, s2_mid;
  logic [7:0]        prev;
  logic              edge_open;
  logic [SLOT_W-1:0] edge_slot;
  logic signed [9:0] diff, thr_s;
  logic              proc, is_start, is_end, open_eff;
  logic [SLOT_W-1:0] slot_eff, mid;
  logic [PROD_W-1:0] prod;
  logic [11:0]       cand_angle;
  logic [CNT_W-1:0]  count;
  logic              has_pend, take;
  logic [11:0]       pend_angle;
  logic [7:0]        pend_range;
  logic              emit, found_next, last_next;
  logic [11:0]       angle_next;
  logic [7:0]        range_next;

  assign in_range = 32'(slot) < SLOTS;
  assign waddr    = SLOT_W'(slot);

  rsoef_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_store (
    .clk     (clk),
    .we      (cmd.write && in_range),
    .waddr   (waddr),
    .wdata   (distance),
    .raddr_a (addr),
    .rdata_a (rdata_a),
    .raddr_b (mid),
    .rdata_b (rdata_b)
  );

  assign status.last_addr = addr == SLOT_W'(SLOTS - 2);

  assign cur         = va ? rdata_a : 8'd0;
  assign mid_reading = vb ? rdata_b : 8'd0;

  assign proc     = s1_valid && (s1_idx != '0);
  assign diff     = $signed({2'b00, prev}) - $signed({2'b00, cur});
  assign thr_s    = $signed({2'b00, edge_threshold});
  assign is_start = proc && (diff >= thr_s);
  assign open_eff = is_start || edge_open;
  assign is_end   = proc && open_eff && ((-diff) >= thr_s);
  assign slot_eff = is_start ? s1_idx : edge_slot;
  assign mid      = slot_eff + ((s1_idx - slot_eff) >> 1);

  assign prod       = PROD_W'(s2_mid) * PROD_W'(angle_step);
  assign cand_angle = (32'(prod) > ANGLE_MAX) ? 12'(ANGLE_MAX) : 12'(prod);
  assign take       = s2_valid && (32'(count) < RESULT_CAP);

  always_comb begin
    emit       = 1'b0;
    found_next = 1'b1;
    angle_next = pend_angle;
    range_next = pend_range;
    last_next  = 1'b0;
    if (cmd.flush) begin
      emit      = 1'b1;
      last_next = 1'b1;
      if (!has_pend) begin
        found_next = 1'b0;
        angle_next = '0;
        range_next = '0;
      end
    end else if (take && has_pend) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    va     <= filled[addr];
    vb     <= filled[mid];
    s1_idx <= addr;
    s2_mid <= mid;
    obstacle_angle <= angle_next;
    obstacle_range <= range_next;
    found          <= found_next;
    last           <= last_next;
    if (s1_valid) begin
      prev <= cur;
    end
    if (take) begin
      pend_angle <= cand_angle;
      pend_range <= mid_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RESET;
      angle_step     <= ANGLE_STEP_RESET;
      filled         <= '0;
      addr           <= '0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      edge_open      <= 1'b0;
      edge_slot      <= '0;
      count          <= '0;
      has_pend       <= 1'b0;
      strobe         <= 1'b0;
    end else begin
      strobe <= emit;
      if (cfg_we) begin
        if (cfg_index == REG_EDGE_THRESHOLD) begin
          edge_threshold <= cfg_data;
        end else begin
          angle_step <= cfg_data[5:0];
        end
      end
      if (cmd.write && in_range) begin
        filled[waddr] <= 1'b1;
      end
      if (cmd.scan_init) begin
        addr      <= '0;
        s1_valid  <= 1'b0;
        s2_valid  <= 1'b0;
        edge_open <= 1'b0;
        edge_slot <= '0;
        count     <= '0;
        has_pend  <= 1'b0;
      end else begin
        s1_valid <= cmd.step;
        s2_valid <= is_end;
        if (cmd.step) begin
          addr <= addr + 1'b1;
        end
        if (proc) begin
          edge_open <= open_eff && !is_end;
          edge_slot <= slot_eff;
        end
        if (take) begin
          count    <= count + 1'b1;
          has_pend <= 1'b1;
        end
        if (cmd.flush) begin
          has_pend <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/range_scan_obstacle_edge_finder_core.sv -----
// Top level of the range scan obstacle edge finder.
// Depends on rsoef_pkg, rsoef_ctrl, rsoef_datapath and the assertion macro header.
//
//   Channel  Handshake           Payload
//   request  start, busy         op, slot, distance
//   result   strobe              found, obstacle_angle, obstacle_range, last
//   config   cfg_we              cfg_index, cfg_data
//
// A write request is taken while idle and busy stays low.
// A scan request holds busy high while the store is walked from slot 0 to slot SLOTS - 2,
// one slot a cycle through read port a, followed by states ST_DRAIN1, ST_DRAIN2 and a flush.
// Results come as single strobed cycles; the final one is in the first cycle with busy low.
// Reset clears the stored readings to zero and the registers to their defaults.
// The receiver cannot stall the results.
`include "range_scan_obstacle_edge_finder_core_assert.svh"
module range_scan_obstacle_edge_finder_core import rsoef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [5:0]  slot,
  input  logic [7:0]  distance,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        strobe,
  output logic        found,
  output logic [11:0] obstacle_angle,
  output logic [7:0]  obstacle_range,
  output logic        last
);

  cmd_t    cmd;
  status_t status;
  logic    empty_fields;

  rsoef_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rsoef_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .slot           (slot),
    .distance       (distance),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .found          (found),
    .obstacle_angle (obstacle_angle),
    .obstacle_range (obstacle_range),
    .last           (last)
  );

  assign empty_fields = (obstacle_angle == 12'd0) && (obstacle_range == 8'd0);

  `RSOEF_ASSERT_NEXT(a_scan_busy, clk, rst, start && !busy && op, busy)
  `RSOEF_ASSERT_NEXT(a_write_quick, clk, rst, start && !busy && !op, !busy)
  `RSOEF_ASSERT_SAME(a_empty_last, clk, rst, strobe && !found, last)
  `RSOEF_ASSERT_SAME(a_empty_zero, clk, rst, strobe && !found, empty_fields)

endmodule
